### rtl/tofr_pkg.sv
// shared types and constants for the time-of-flight range frame reader
`timescale 1ns / 1ps
`default_nettype none

package tofr_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int INDEX_W     = 4;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [7:0] HDR_SYNC  = 8'h57;
  localparam logic [7:0] RESP_MARK = 8'h00;
  localparam logic [7:0] FRAME_ID  = 8'h00;

  localparam logic [2:0] ADDR_RETRY_LIMIT   = 3'd0;
  localparam logic [2:0] ADDR_TIMEOUT_TICKS = 3'd4;

  localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;
  localparam logic [15:0] TICK_MAX            = 16'hFFFF;

  typedef struct packed {
    logic        send_command;
    logic        abort_receive;
    logic        busy_res;
    logic        reading_valid;
    logic [23:0] distance_mm;
    logic [7:0]  range_status;
    logic [7:0]  range_precision;
    logic [15:0] signal_level;
    logic [31:0] sensor_time;
    logic        frame_rejected;
    logic        gave_up;
  } result_t;

endpackage

`default_nettype wire

### rtl/tofr_skid.sv
// result register with skid stage between engine and result channel
`timescale 1ns / 1ps
`default_nettype none

module tofr_skid
  import tofr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         res_valid,
  input  wire logic    res_stall,
  output result_t      res_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = res_valid && !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || pop) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || pop) begin
      res_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/tof_range_frame_reader.sv
// top level of the time-of-flight range frame reader
`timescale 1ns / 1ps
`default_nettype none

// Query engine for a serial time-of-flight range sensor. Each request transfer
// (read request, received byte or timer tick) yields exactly one result
// transfer. The whole update is done in the cycle the request is taken, so a
// request can be taken every clock while the result side keeps up; the result
// register plus a one-entry skid stage let one more request in while a result
// is stalled, then req_stall is raised until the skid stage drains. Registers
// at byte address 0 (retry_limit) and 4 (timeout_ticks) are written through
// the APB port, and the user must write them only while idle (not enforced).
module tof_range_frame_reader
  import tofr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  rx_byte,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             send_command,
  output logic             abort_receive,
  output logic             busy_res,
  output logic             reading_valid,
  output logic [23:0]      distance_mm,
  output logic [7:0]       range_status,
  output logic [7:0]       range_precision,
  output logic [15:0]      signal_level,
  output logic [31:0]      sensor_time,
  output logic             frame_rejected,
  output logic             gave_up,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0]  retry_limit;
  logic [15:0] timeout_ticks;

  logic               reading_phase, reading_phase_next;
  logic [INDEX_W-1:0] byte_index, byte_index_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [3:0]         retry_count, retry_count_next;
  logic [15:0]        tick_count, tick_count_next;
  logic [31:0]        last_time, last_time_next;
  logic               held_valid, held_valid_next;
  logic [23:0]        held_distance, held_distance_next;
  logic [7:0]         held_status, held_status_next;
  logic [7:0]         held_precision, held_precision_next;
  logic [15:0]        held_strength, held_strength_next;
  logic [7:0]         frame_store [FRAME_BYTES];

  logic        accept;
  logic        store_write;
  logic        send, abort_rx, rejected, gaveup;
  logic [3:0]  retry_inc;
  logic        retry_ok;
  logic [15:0] tick_inc;
  logic [31:0] frame_time;
  logic        frame_ok;
  logic        cfg_write;
  result_t     result;
  result_t     res_data;
  logic        skid_full;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit   <= RETRY_LIMIT_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (paddr)
        ADDR_RETRY_LIMIT:   retry_limit   <= pwdata[3:0];
        ADDR_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_RETRY_LIMIT:   prdata = {28'd0, retry_limit};
      ADDR_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks};
      default:            prdata = 32'd0;
    endcase
  end

  // engine
  assign req_stall = skid_full;
  assign accept    = req_valid && !req_stall;

  assign retry_inc  = retry_count + 4'd1;
  assign retry_ok   = retry_inc < retry_limit;
  assign tick_inc   = (tick_count == TICK_MAX) ? tick_count : tick_count + 16'd1;
  assign frame_time = {frame_store[7], frame_store[6], frame_store[5], frame_store[4]};
  assign frame_ok   = (frame_store[0] == HDR_SYNC) && (frame_store[1] == RESP_MARK) &&
                      (frame_store[3] == FRAME_ID) && (frame_time != last_time) &&
                      (rx_byte == running_sum);

  always_comb begin
    reading_phase_next  = reading_phase;
    byte_index_next     = byte_index;
    running_sum_next    = running_sum;
    retry_count_next    = retry_count;
    tick_count_next     = tick_count;
    last_time_next      = last_time;
    held_valid_next     = held_valid;
    held_distance_next  = held_distance;
    held_status_next    = held_status;
    held_precision_next = held_precision;
    held_strength_next  = held_strength;
    send        = 1'b0;
    abort_rx    = 1'b0;
    rejected    = 1'b0;
    gaveup      = 1'b0;
    store_write = 1'b0;
    case (operation)
      OP_READ: begin
        if (!reading_phase) begin
          reading_phase_next = 1'b1;
          retry_count_next   = '0;
          byte_index_next    = '0;
          running_sum_next   = '0;
          tick_count_next    = '0;
          send               = 1'b1;
        end
      end
      OP_BYTE: begin
        if (reading_phase) begin
          store_write = 1'b1;
          if (byte_index != INDEX_W'(FRAME_BYTES - 1)) begin
            running_sum_next = running_sum + rx_byte;
            byte_index_next  = byte_index + INDEX_W'(1);
          end else if (frame_ok) begin
            held_valid_next     = 1'b1;
            held_distance_next  = {frame_store[10], frame_store[9], frame_store[8]};
            held_status_next    = frame_store[11];
            held_strength_next  = {frame_store[13], frame_store[12]};
            held_precision_next = frame_store[14];
            last_time_next      = frame_time;
            reading_phase_next  = 1'b0;
            retry_count_next    = '0;
            byte_index_next     = '0;
            running_sum_next    = '0;
            tick_count_next     = '0;
          end else begin
            rejected         = 1'b1;
            retry_count_next = retry_inc;
            byte_index_next  = '0;
            running_sum_next = '0;
            tick_count_next  = '0;
            if (retry_ok) begin
              send = 1'b1;
            end else begin
              gaveup             = 1'b1;
              held_valid_next    = 1'b0;
              reading_phase_next = 1'b0;
              retry_count_next   = '0;
            end
          end
        end
      end
      OP_TICK: begin
        if (reading_phase) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            abort_rx         = 1'b1;
            retry_count_next = retry_inc;
            byte_index_next  = '0;
            running_sum_next = '0;
            tick_count_next  = '0;
            if (retry_ok) begin
              send = 1'b1;
            end else begin
              gaveup             = 1'b1;
              held_valid_next    = 1'b0;
              reading_phase_next = 1'b0;
              retry_count_next   = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_phase  <= 1'b0;
      byte_index     <= '0;
      running_sum    <= '0;
      retry_count    <= '0;
      tick_count     <= '0;
      last_time      <= '0;
      held_valid     <= 1'b0;
      held_distance  <= '0;
      held_status    <= '0;
      held_precision <= '0;
      held_strength  <= '0;
    end else if (accept) begin
      reading_phase  <= reading_phase_next;
      byte_index     <= byte_index_next;
      running_sum    <= running_sum_next;
      retry_count    <= retry_count_next;
      tick_count     <= tick_count_next;
      last_time      <= last_time_next;
      held_valid     <= held_valid_next;
      held_distance  <= held_distance_next;
      held_status    <= held_status_next;
      held_precision <= held_precision_next;
      held_strength  <= held_strength_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_write) begin
      frame_store[byte_index] <= rx_byte;
    end
  end

  always_comb begin
    result.send_command    = send;
    result.abort_receive   = abort_rx;
    result.busy_res        = reading_phase_next;
    result.reading_valid   = held_valid_next;
    result.distance_mm     = held_distance_next;
    result.range_status    = held_status_next;
    result.range_precision = held_precision_next;
    result.signal_level    = held_strength_next;
    result.sensor_time     = last_time_next;
    result.frame_rejected  = rejected;
    result.gave_up         = gaveup;
  end

  tofr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (skid_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign send_command    = res_data.send_command;
  assign abort_receive   = res_data.abort_receive;
  assign busy_res        = res_data.busy_res;
  assign reading_valid   = res_data.reading_valid;
  assign distance_mm     = res_data.distance_mm;
  assign range_status    = res_data.range_status;
  assign range_precision = res_data.range_precision;
  assign signal_level    = res_data.signal_level;
  assign sensor_time     = res_data.sensor_time;
  assign frame_rejected  = res_data.frame_rejected;
  assign gave_up         = res_data.gave_up;

  // checks
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !reading_phase |-> (byte_index == '0) && (tick_count == '0) && (retry_count == '0))
    else $error("idle with counters not cleared");

  a_give_up_no_send: assert property (@(posedge clk) disable iff (rst)
    res_valid && gave_up |-> !send_command && !busy_res && !reading_valid)
    else $error("give-up transfer inconsistent");

  a_abort_not_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(abort_receive && frame_rejected))
    else $error("abort and reject in one transfer");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    req_stall |=> $stable(reading_phase) && $stable(byte_index) && $stable(last_time))
    else $error("state changed while request side stalled");

endmodule

`default_nettype wire
